// ----- hw/rtl/sdtq_pkg.sv -----
// Shared types, sizes and codes of the sorted deadline timer queue.
`default_nettype none

package sdtq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W         = $clog2(MAX_RESULTS);
    localparam int TIME_W        = 64;
    localparam int ID_W          = 8;
    localparam int CFG_W         = 32;
    localparam int DELAY_W       = 33;
    localparam int ADDR_W        = 3;

    localparam int US_PER_SECOND = 1000000;
    localparam int REM_W         = $clog2(US_PER_SECOND);
    localparam int DIV_BITS      = 4;
    localparam int DIV_STEPS     = TIME_W / DIV_BITS;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0]  TPS_RESET   = CFG_W'(10000000);
    localparam logic [CFG_W-1:0]  SCHED_RESET = CFG_W'(US_PER_SECOND / 32);
    localparam logic [TIME_W-1:0] NO_DEADLINE = '1;

    localparam logic [1:0] OP_INS_SEC = 2'd0;
    localparam logic [1:0] OP_INS_US  = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;
    localparam logic [1:0] OP_FLAG    = 2'd3;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;
    localparam logic [1:0] KIND_FLAG    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEGATIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic REG_TPS   = 1'b0;
    localparam logic REG_SCHED = 1'b1;

    localparam logic [ID_W-1:0] SCHED_HANDLE = '0;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   handle;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/sdtq_cell.sv -----
// One slot of the sorted queue: holds an event and trades it with its neighbors.
`default_nettype none

module sdtq_cell (
    input  wire logic                i_clk,
    input  wire sdtq_pkg::t_cell_ctl i_ctl,
    input  wire sdtq_pkg::t_entry    i_key,
    input  wire logic                i_occupied,
    input  wire logic                i_left_keep,
    input  wire sdtq_pkg::t_entry    i_left,
    input  wire sdtq_pkg::t_entry    i_right,
    output sdtq_pkg::t_entry         o_ent,
    output logic                     o_keep
);
    import sdtq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // Equal deadlines stay ahead of the new event.
    assign o_keep = i_occupied && (r_ent.deadline <= i_key.deadline);
    assign o_ent  = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.pop) begin
            n_ent = i_right;
        end else if (i_ctl.ins && !o_keep) begin
            n_ent = i_left_keep ? i_key : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sdtq_div.sv -----
// Iterative divider of a 64-bit value by one million, four quotient bits per cycle.
`default_nettype none

module sdtq_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sdtq_pkg::TIME_W-1:0] i_dividend,
    output logic                             o_done,
    output logic [sdtq_pkg::TIME_W-1:0]      o_quot
);
    import sdtq_pkg::*;

    localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(US_PER_SECOND);

    logic [TIME_W-1:0] r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W-1:0] n_quo;
    logic [REM_W-1:0]  n_rem;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
        logic [REM_W:0] v_trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int j = 0; j < DIV_BITS; j++) begin
            v_trial = {n_rem, n_quo[TIME_W-1]};
            n_quo   = {n_quo[TIME_W-2:0], 1'b0};
            if (v_trial >= DIVISOR) begin
                v_trial  = v_trial - DIVISOR;
                n_quo[0] = 1'b1;
            end
            n_rem = v_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_deadline_timer_queue_top.sv -----
// Top level of the sorted deadline timer queue: sequencer, cell chain and register port.
//
// The queue holds up to 16 timer events in a chain of cells kept sorted by deadline;
// an insert is settled by all cells in parallel, a pop shifts the chain by one.
// Items are taken one at a time. A seconds insert steps through multiply, deadline add,
// insert and reply; a microsecond insert adds the divide by one million, which retires
// four quotient bits a cycle, between multiply and deadline add. A flag query goes
// straight to its reply. An expiry check pops its expired events, re-arms each
// scheduler tick it pops (multiply and divide), then gives out its results one by one
// as the output takes them. No clearing pass follows reset. The next item may be
// offered while the last result of the previous one still waits at the output.
`default_nettype none

module sorted_deadline_timer_queue_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [sdtq_pkg::TIME_W-1:0]       i_now_time,
    input  wire logic signed [sdtq_pkg::DELAY_W-1:0] i_delay_amount,
    input  wire logic [sdtq_pkg::ID_W-1:0]         i_event_id,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_result_kind,
    output logic [1:0]                             o_status,
    output logic [sdtq_pkg::ID_W-1:0]              o_expired_id,
    output logic                                   o_tick_pending,
    output logic [sdtq_pkg::TIME_W-1:0]            o_compare_value,
    output logic                                   o_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sdtq_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [sdtq_pkg::CFG_W-1:0]        pwdata,
    output logic [sdtq_pkg::CFG_W-1:0]             prdata,
    output logic                                   pready
);
    import sdtq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_KEY   = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_REPLY = 3'd7;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_flag;
    logic [CFG_W-1:0]  r_tps;
    logic [CFG_W-1:0]  r_sched;
    logic              r_ovalid;
    logic              r_div_go;
    logic              r_tick;
    logic [CNT_W-1:0]  r_pops;
    logic [CNT_W-1:0]  r_limit;
    logic [RES_W-1:0]  r_n;
    logic [RES_W-1:0]  r_left;

    logic [1:0]        r_op;
    logic [TIME_W-1:0] r_now;
    logic [CFG_W-1:0]  r_mul_a;
    logic [ID_W-1:0]   r_id;
    logic [1:0]        r_status;
    logic [1:0]        r_kind;
    logic              r_pend;
    logic [TIME_W-1:0] r_prod;
    logic [TIME_W-1:0] r_delta;
    t_entry            r_key;
    logic [ID_W-1:0]   r_ids [MAX_RESULTS];

    logic [1:0]        r_o_kind;
    logic [1:0]        r_o_status;
    logic [ID_W-1:0]   r_o_id;
    logic              r_o_pend;
    logic [TIME_W-1:0] r_o_cmp;
    logic              r_o_last;

    t_entry                 w_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_occ;
    t_cell_ctl              w_ctl;
    t_entry                 w_head;
    logic                   w_in_acc;
    logic                   w_cfg_wr;
    logic                   w_out_free;
    logic                   w_full;
    logic                   w_pop;
    logic [TIME_W-1:0]      w_cmp;
    logic                   w_emit_load;
    logic                   w_emit_last;
    logic                   w_reply_load;
    logic [TIME_W-1:0]      w_prod;
    logic                   w_div_done;
    logic [TIME_W-1:0]      w_quot;
    logic                   w_sec_path;

    assign w_head       = w_ent[0];
    assign w_in_acc     = i_in_valid && (r_state == S_IDLE);
    assign w_cfg_wr     = psel && penable && pwrite;
    assign w_out_free   = !r_ovalid || i_out_ready;
    assign w_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_cmp        = (r_count != '0) ? w_head.deadline : NO_DEADLINE;
    assign w_emit_load  = (r_state == S_EMIT) && w_out_free;
    assign w_emit_last  = (r_n == '0) || (r_left == RES_W'(1));
    assign w_reply_load = (r_state == S_REPLY) && w_out_free;
    assign w_prod       = 64'(r_mul_a) * 64'(r_tps);
    assign w_sec_path   = (r_op == OP_INS_SEC) && !r_tick;

    // A check pops only events present at its start, and at most one result buffer full.
    assign w_pop = (r_state == S_CHK) && (r_count != '0) && (r_pops != r_limit)
                   && (r_n != RES_W'(MAX_RESULTS)) && (w_head.deadline <= r_now);

    assign w_ctl.ins = (r_state == S_INS);
    assign w_ctl.pop = w_pop;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_keep;

        if (g == 0) begin : g_first
            assign w_left      = r_key;
            assign w_left_keep = 1'b1;
        end else begin : g_inner
            assign w_left      = w_ent[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign w_right = w_ent[g];
        end else begin : g_mid
            assign w_right = w_ent[g+1];
        end

        assign w_occ[g] = (r_count > CNT_W'(g));

        sdtq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_key       (r_key),
            .i_occupied  (w_occ[g]),
            .i_left_keep (w_left_keep),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_ent       (w_ent[g]),
            .o_keep      (w_keep[g])
        );
    end

    sdtq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_flag   <= 1'b0;
            r_tps    <= TPS_RESET;
            r_sched  <= SCHED_RESET;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
            r_tick   <= 1'b0;
            r_pops   <= '0;
            r_limit  <= '0;
            r_n      <= '0;
            r_left   <= '0;
        end else begin
            r_div_go <= 1'b0;

            if (w_cfg_wr) begin
                if (paddr[2] == REG_TPS) begin
                    r_tps <= pwdata;
                end else begin
                    r_sched <= pwdata;
                end
            end

            if (w_emit_load || w_reply_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_opcode)
                            OP_INS_SEC: begin
                                r_state <= (i_delay_amount[DELAY_W-1] || w_full)
                                           ? S_REPLY : S_MUL;
                            end
                            OP_INS_US: begin
                                r_state <= w_full ? S_REPLY : S_MUL;
                            end
                            OP_CHECK: begin
                                r_limit <= r_count;
                                r_pops  <= '0;
                                r_n     <= '0;
                                r_state <= S_CHK;
                            end
                            OP_FLAG: begin
                                r_flag  <= 1'b0;
                                r_state <= S_REPLY;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: begin
                    if (w_sec_path) begin
                        r_state <= S_KEY;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_tick) begin
                        r_tick  <= 1'b0;
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_REPLY;
                    end
                end
                S_CHK: begin
                    if (w_pop) begin
                        r_count <= r_count - CNT_W'(1);
                        r_pops  <= r_pops + CNT_W'(1);
                        if (w_head.handle == SCHED_HANDLE) begin
                            r_flag  <= 1'b1;
                            r_tick  <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_n <= r_n + RES_W'(1);
                        end
                    end else begin
                        r_left  <= r_n;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_left <= r_left - RES_W'(1);
                        if (w_emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_REPLY: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_opcode;
            r_now   <= i_now_time;
            r_id    <= i_event_id;
            r_mul_a <= i_delay_amount[CFG_W-1:0];
            r_kind  <= (i_opcode == OP_FLAG) ? KIND_FLAG : KIND_INSERT;
            r_pend  <= (i_opcode == OP_FLAG) ? r_flag : 1'b0;
            priority if (i_opcode == OP_INS_SEC && i_delay_amount[DELAY_W-1]) begin
                r_status <= ST_NEGATIVE;
            end else if ((i_opcode == OP_INS_SEC || i_opcode == OP_INS_US) && w_full) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_OK;
            end
        end

        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end

        if (r_state == S_DIV && w_div_done) begin
            r_delta <= (w_quot == '0) ? TIME_W'(1) : w_quot;
        end

        if (r_state == S_KEY) begin
            r_key.deadline <= r_now + (w_sec_path ? r_prod : r_delta);
            r_key.handle   <= r_tick ? SCHED_HANDLE : r_id;
        end

        if (w_pop && w_head.handle == SCHED_HANDLE) begin
            r_mul_a <= r_sched;
        end

        if (w_pop && w_head.handle != SCHED_HANDLE) begin
            r_ids[r_n[IDX_W-1:0]] <= w_head.handle;
        end else if (w_emit_load) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_ids[k] <= r_ids[k+1];
            end
        end

        if (w_emit_load) begin
            r_o_kind   <= (r_n == '0) ? KIND_NONE : KIND_EXPIRED;
            r_o_status <= ST_OK;
            r_o_id     <= (r_n == '0) ? '0 : r_ids[0];
            r_o_pend   <= 1'b0;
            r_o_cmp    <= w_cmp;
            r_o_last   <= w_emit_last;
        end else if (w_reply_load) begin
            r_o_kind   <= r_kind;
            r_o_status <= r_status;
            r_o_id     <= '0;
            r_o_pend   <= r_pend;
            r_o_cmp    <= w_cmp;
            r_o_last   <= 1'b1;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_result_kind   = r_o_kind;
    assign o_status        = r_o_status;
    assign o_expired_id    = r_o_id;
    assign o_tick_pending  = r_o_pend;
    assign o_compare_value = r_o_cmp;
    assign o_last          = r_o_last;
    assign pready          = 1'b1;
    assign prdata          = (paddr[1:0] != 2'b00) ? '0 :
                             (paddr[2] == REG_TPS) ? r_tps : r_sched;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |-> (!w_full && !w_ctl.pop))
        else $error("insert into a full queue or during a pop");

    a_pop_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> (r_count != '0 && r_pops < r_limit))
        else $error("pop beyond the events present at check start");

    a_flag_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode == OP_FLAG) |=> !r_flag)
        else $error("scheduler flag not cleared by a flag query");

endmodule

`default_nettype wire
